>>> rtl/pjtt_pkg.sv
// ----------------------------------------------------------------------------
// pjtt_pkg
// Shared types and codes for the periodic job timer table: command codes,
// result status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package pjtt_pkg;

  // Field widths fixed by the interface.
  localparam int ID_W  = 16;
  localparam int TAG_W = 32;

  // Command codes carried on in_cmd; the remaining code is ignored.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_FIRED     = 3'd0,
    STAT_CREATED   = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_SWEEP,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture the command and clear the sweep bookkeeping
    logic create;  // append a job, or report a full table
    logic issue;   // read the next table entry of the sweep
    logic finish;  // give the closing result and commit the new fill count
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;        // no jobs in the table
    logic last_issued;  // the entry being read is the last one in use
  } sts_t;

endpackage

>>> rtl/pjtt_ctrl.sv
// ----------------------------------------------------------------------------
// pjtt_ctrl
// Controller of the job table. Accepts a command, walks the datapath through
// a create, or through a sweep of the table for a tick or a remove.
// ----------------------------------------------------------------------------
module pjtt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_cmd,
  input  pjtt_pkg::sts_t   sts,
  output pjtt_pkg::ctl_t   ctl,
  output logic             busy
);

  pjtt_pkg::state_t state_r;
  pjtt_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pjtt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    unique case (state_r)
      pjtt_pkg::S_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
        if (start) begin
          unique case (in_cmd) inside
            pjtt_pkg::CMD_CREATE: begin
              state_nxt = pjtt_pkg::S_CREATE;
            end
            pjtt_pkg::CMD_TICK, pjtt_pkg::CMD_REMOVE: begin
              state_nxt = sts.empty ? pjtt_pkg::S_FINISH : pjtt_pkg::S_SWEEP;
            end
            default: begin
              state_nxt = pjtt_pkg::S_IDLE;
            end
          endcase
        end
      end
      pjtt_pkg::S_CREATE: begin
        ctl.create = 1'b1;
        state_nxt  = pjtt_pkg::S_IDLE;
      end
      pjtt_pkg::S_SWEEP: begin
        ctl.issue = 1'b1;
        if (sts.last_issued) begin
          state_nxt = pjtt_pkg::S_DRAIN;
        end
      end
      pjtt_pkg::S_DRAIN: begin
        // The last entry read is processed in this cycle.
        state_nxt = pjtt_pkg::S_FINISH;
      end
      pjtt_pkg::S_FINISH: begin
        ctl.finish = 1'b1;
        state_nxt  = pjtt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pjtt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pjtt_datapath.sv
// ----------------------------------------------------------------------------
// pjtt_datapath
// Job table storage and processing. Jobs are packed in entries 0..n-1 in
// creation order. A sweep reads one entry a cycle and writes kept entries
// back at a separate write index, so dropped jobs close up without gaps.
// ----------------------------------------------------------------------------
module pjtt_datapath #(
  parameter int MAX_JOBS    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pjtt_pkg::ctl_t              ctl,
  output pjtt_pkg::sts_t              sts,
  input  logic [1:0]                  in_cmd,
  input  logic [15:0]                 in_period,
  input  logic [15:0]                 in_repeat_count,
  input  logic [15:0]                 in_job_id,
  input  logic [31:0]                 in_tag,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [pjtt_pkg::ID_W-1:0]   out_id,
  output logic [pjtt_pkg::TAG_W-1:0]  out_tag,
  output logic                        out_final_fire,
  output logic                        out_last
);

  localparam int IW = $clog2(MAX_JOBS);
  localparam int NW = $clog2(MAX_JOBS + 1);
  localparam int CW = COUNT_WIDTH;
  localparam int DW = pjtt_pkg::ID_W;
  localparam int TW = pjtt_pkg::TAG_W;

  // Table memories, one write and one registered read port each.
  logic [DW-1:0] mem_id   [MAX_JOBS];
  logic [CW-1:0] mem_per  [MAX_JOBS];
  logic [CW-1:0] mem_cnt  [MAX_JOBS];
  logic [CW-1:0] mem_rem  [MAX_JOBS];
  logic [TW-1:0] mem_tag  [MAX_JOBS];

  // Captured command.
  logic [1:0]    cmd_r;
  logic [DW-1:0] jid_r;
  logic [CW-1:0] per_r;
  logic [CW-1:0] rep_r;
  logic [TW-1:0] tag_r;

  // Read data of the entry under processing.
  logic [DW-1:0] rd_id_r;
  logic [CW-1:0] rd_per_r;
  logic [CW-1:0] rd_cnt_r;
  logic [CW-1:0] rd_rem_r;
  logic [TW-1:0] rd_tag_r;

  // Control state.
  logic [NW-1:0] n_r,          n_nxt;
  logic [DW-1:0] next_id_r,    next_id_nxt;
  logic [IW-1:0] rd_i_r,       rd_i_nxt;
  logic [NW-1:0] wr_i_r,       wr_i_nxt;
  logic          proc_valid_r, proc_valid_nxt;
  logic          hit_r,        hit_nxt;
  logic          hold_valid_r, hold_valid_nxt;
  logic          out_valid_r,  out_valid_nxt;

  // Held fire result and output payload.
  logic [DW-1:0]     hold_id_r,     hold_id_nxt;
  logic [TW-1:0]     hold_tag_r,    hold_tag_nxt;
  logic              hold_fin_r,    hold_fin_nxt;
  pjtt_pkg::status_t out_status_r,  out_status_nxt;
  logic [DW-1:0]     out_id_r,      out_id_nxt;
  logic [TW-1:0]     out_tag_r,     out_tag_nxt;
  logic              out_fin_r,     out_fin_nxt;
  logic              out_last_r,    out_last_nxt;

  // Memory write port.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] w_id;
  logic [CW-1:0] w_per;
  logic [CW-1:0] w_cnt;
  logic [CW-1:0] w_rem;
  logic [TW-1:0] w_tag;

  // Tick update of the entry under processing.
  logic          is_tick;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] rem_dec;
  logic          fire;
  logic          fin;
  logic          drop;
  logic [CW-1:0] new_cnt;
  logic [CW-1:0] new_rem;

  assign is_tick = (cmd_r == pjtt_pkg::CMD_TICK);
  assign cnt_inc = rd_cnt_r + CW'(1);
  assign rem_dec = rd_rem_r - CW'(1);
  assign fire    = (rd_per_r != '0) && (cnt_inc == rd_per_r);
  assign fin     = fire && (rd_rem_r != '0) && (rem_dec == '0);
  assign new_cnt = fire ? '0 : ((rd_per_r != '0) ? cnt_inc : rd_cnt_r);
  assign new_rem = (fire && (rd_rem_r != '0)) ? rem_dec : rd_rem_r;

  // A tick drops a job whose repeats ran out; a remove drops the first match.
  assign drop = is_tick ? fin : (!hit_r && (rd_id_r == jid_r));

  // Status to the controller.
  assign sts.empty       = (n_r == '0);
  assign sts.last_issued = (NW'(rd_i_r) == (n_r - NW'(1)));

  // Next-state logic for the sweep, the create and the closing result.
  always_comb begin
    n_nxt          = n_r;
    next_id_nxt    = next_id_r;
    rd_i_nxt       = rd_i_r;
    wr_i_nxt       = wr_i_r;
    proc_valid_nxt = ctl.issue;
    hit_nxt        = hit_r;
    hold_valid_nxt = hold_valid_r;
    hold_id_nxt    = hold_id_r;
    hold_tag_nxt   = hold_tag_r;
    hold_fin_nxt   = hold_fin_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_tag_nxt    = out_tag_r;
    out_fin_nxt    = out_fin_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_i_r[IW-1:0];
    w_id           = rd_id_r;
    w_per          = rd_per_r;
    w_cnt          = rd_cnt_r;
    w_rem          = rd_rem_r;
    w_tag          = rd_tag_r;

    // New command: restart the sweep bookkeeping.
    if (ctl.accept) begin
      rd_i_nxt       = '0;
      wr_i_nxt       = '0;
      hit_nxt        = 1'b0;
      hold_valid_nxt = 1'b0;
    end

    if (ctl.issue) begin
      rd_i_nxt = rd_i_r + IW'(1);
    end

    // Process the entry read in the previous cycle.
    if (proc_valid_r) begin
      if (is_tick) begin
        w_cnt = new_cnt;
        w_rem = new_rem;
        if (fire) begin
          // A fire is held back one event so the last one can be marked.
          if (hold_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pjtt_pkg::STAT_FIRED;
            out_id_nxt     = hold_id_r;
            out_tag_nxt    = hold_tag_r;
            out_fin_nxt    = hold_fin_r;
            out_last_nxt   = 1'b0;
          end
          hold_valid_nxt = 1'b1;
          hold_id_nxt    = rd_id_r;
          hold_tag_nxt   = rd_tag_r;
          hold_fin_nxt   = fin;
        end
      end else if (drop) begin
        hit_nxt = 1'b1;
      end
      if (!drop) begin
        mem_we   = 1'b1;
        wr_i_nxt = wr_i_r + NW'(1);
      end
    end

    // Append a job at the end of the table, or report a full table.
    if (ctl.create) begin
      out_valid_nxt = 1'b1;
      out_tag_nxt   = '0;
      out_fin_nxt   = 1'b0;
      out_last_nxt  = 1'b1;
      if (n_r == NW'(MAX_JOBS)) begin
        out_status_nxt = pjtt_pkg::STAT_FULL;
        out_id_nxt     = '0;
      end else begin
        mem_we         = 1'b1;
        mem_waddr      = n_r[IW-1:0];
        w_id           = next_id_r;
        w_per          = per_r;
        w_cnt          = '0;
        w_rem          = rep_r;
        w_tag          = tag_r;
        out_status_nxt = pjtt_pkg::STAT_CREATED;
        out_id_nxt     = next_id_r;
        n_nxt          = n_r + NW'(1);
        next_id_nxt    = next_id_r + DW'(1);
      end
    end

    // Close the sweep: commit the fill count and give the final result.
    if (ctl.finish) begin
      n_nxt = wr_i_r;
      if (is_tick) begin
        if (hold_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pjtt_pkg::STAT_FIRED;
          out_id_nxt     = hold_id_r;
          out_tag_nxt    = hold_tag_r;
          out_fin_nxt    = hold_fin_r;
          out_last_nxt   = 1'b1;
        end
        hold_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = hit_r ? pjtt_pkg::STAT_REMOVED : pjtt_pkg::STAT_NOT_FOUND;
        out_id_nxt     = jid_r;
        out_tag_nxt    = '0;
        out_fin_nxt    = 1'b0;
        out_last_nxt   = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      next_id_r    <= '0;
      rd_i_r       <= '0;
      wr_i_r       <= '0;
      proc_valid_r <= 1'b0;
      hit_r        <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      n_r          <= n_nxt;
      next_id_r    <= next_id_nxt;
      rd_i_r       <= rd_i_nxt;
      wr_i_r       <= wr_i_nxt;
      proc_valid_r <= proc_valid_nxt;
      hit_r        <= hit_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= in_cmd;
      jid_r <= in_job_id;
      per_r <= CW'(in_period);
      rep_r <= CW'(in_repeat_count);
      tag_r <= in_tag;
    end
    hold_id_r    <= hold_id_nxt;
    hold_tag_r   <= hold_tag_nxt;
    hold_fin_r   <= hold_fin_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_tag_r    <= out_tag_nxt;
    out_fin_r    <= out_fin_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Table memories: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[mem_waddr]  <= w_id;
      mem_per[mem_waddr] <= w_per;
      mem_cnt[mem_waddr] <= w_cnt;
      mem_rem[mem_waddr] <= w_rem;
      mem_tag[mem_waddr] <= w_tag;
    end
    if (ctl.issue) begin
      rd_id_r  <= mem_id[rd_i_r];
      rd_per_r <= mem_per[rd_i_r];
      rd_cnt_r <= mem_cnt[rd_i_r];
      rd_rem_r <= mem_rem[rd_i_r];
      rd_tag_r <= mem_tag[rd_i_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_id         = out_id_r;
  assign out_tag        = out_tag_r;
  assign out_final_fire = out_fin_r;
  assign out_last       = out_last_r;

endmodule

>>> rtl/periodic_job_timer_table.sv
// Create: busy in the create state that follows the accept.
// Tick and remove: busy in the sweep, drain and finish states, or in the finish
// state alone if the table is empty; the sweep reads one table entry a cycle
// through one memory port. Any final result shows in the cycle busy falls.
// Reset is synchronous: the table empties and ids restart from zero.
// Results are strobed by out_valid for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// periodic_job_timer_table
// Ordered table of periodic jobs with create, remove by id and tick commands.
// A tick advances each job and reports fire events in table order.
// ----------------------------------------------------------------------------
module periodic_job_timer_table #(
  parameter int MAX_JOBS    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_period,
  input  logic [15:0] in_repeat_count,
  input  logic [15:0] in_job_id,
  input  logic [31:0] in_tag,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_id,
  output logic [31:0] out_tag,
  output logic        out_final_fire,
  output logic        out_last
);

  pjtt_pkg::ctl_t ctl;
  pjtt_pkg::sts_t sts;

  // Sequencing of each command.
  pjtt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Table storage, job update and result registers.
  pjtt_datapath #(
    .MAX_JOBS    (MAX_JOBS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_period       (in_period),
    .in_repeat_count (in_repeat_count),
    .in_job_id       (in_job_id),
    .in_tag          (in_tag),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_tag         (out_tag),
    .out_final_fire  (out_final_fire),
    .out_last        (out_last)
  );

endmodule

>>> rtl/pjtt_checker.sv
// ----------------------------------------------------------------------------
// pjtt_checker
// Port-level checks of the job timer table, bound to the top level.
// ----------------------------------------------------------------------------
module pjtt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_tag,
  input logic        out_final_fire,
  input logic        out_last
);

  // Reset leaves the block idle with no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("result or busy after reset");

  // A create transfer is answered by a closing result with a created or full status.
  a_create_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == pjtt_pkg::CMD_CREATE) |-> ##2
    (out_valid && out_last &&
     (out_status == pjtt_pkg::STAT_CREATED || out_status == pjtt_pkg::STAT_FULL)))
    else $error("create not answered in time");

  // Only fire results carry a tag or a final flag, and others close the item.
  a_nonfire_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pjtt_pkg::STAT_FIRED) |->
    (out_last && out_tag == '0 && !out_final_fire))
    else $error("malformed non-fire result");

  // The closing result of an item is never directly followed by another.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after a closing result");

endmodule

bind periodic_job_timer_table pjtt_checker u_pjtt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_tag        (out_tag),
  .out_final_fire (out_final_fire),
  .out_last       (out_last)
);
